// ===== design/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon crossing test block.
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_WIDTH_DEF  = 24;

    // Item kind carried on s_tuser
    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // Per-cell control of the vertex ring
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    // Control into the edge evaluator
    typedef struct packed {
        logic vld;
        logic active;
        logic clear;
    } edge_ctrl_t;

    // Status out of the edge evaluator
    typedef struct packed {
        logic busy;
        logic parity;
    } edge_stat_t;

endpackage

// ===== design/pip_cell.sv =====
// One vertex cell of the rotating vertex ring.
module pip_cell #(
    parameter int W = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                aclk,
    input  pip_pkg::cell_ctrl_t ctrl,
    input  logic signed [W-1:0] load_x,
    input  logic signed [W-1:0] load_y,
    input  logic signed [W-1:0] nbr_x,
    input  logic signed [W-1:0] nbr_y,
    output logic signed [W-1:0] vx,
    output logic signed [W-1:0] vy
);
    import pip_pkg::*;

    logic signed [W-1:0] x_reg, y_reg;

    // load wins; shifting only happens during a query, when no load occurs
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            x_reg <= load_x;
            y_reg <= load_y;
        end else if (ctrl.shift) begin
            x_reg <= nbr_x;
            y_reg <= nbr_y;
        end
    end

    assign vx = x_reg;
    assign vy = y_reg;

endmodule

// ===== design/pip_edge.sv =====
// Three-stage edge evaluator: span/differences, products, compare and parity.
module pip_edge #(
    parameter int W = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pip_pkg::edge_ctrl_t ctrl,
    input  logic signed [W-1:0] qx,
    input  logic signed [W-1:0] qy,
    input  logic signed [W-1:0] x0,
    input  logic signed [W-1:0] y0,
    input  logic signed [W-1:0] x1,
    input  logic signed [W-1:0] y1,
    output pip_pkg::edge_stat_t stat
);
    import pip_pkg::*;

    localparam int DW = W + 1;
    localparam int PW = 2 * DW;

    // stage A
    logic signed [W-1:0]  xl, yl, xh, yh;
    logic                 span;
    logic                 a_vld_reg, a_act_reg, a_gtl_reg, a_gth_reg;
    logic signed [DW-1:0] a_dyl_reg, a_dxe_reg, a_dye_reg, a_dxp_reg;
    logic signed [DW-1:0] dyl_next, dxe_next, dye_next, dxp_next;
    // stage B
    logic                 b_vld_reg, b_act_reg, b_gtl_reg, b_gth_reg;
    logic signed [PW-1:0] b_pl_reg, b_pr_reg, pl_next, pr_next;
    // stage C
    logic                 beyond, toggle, parity_reg, parity_next;

    always_comb begin
        if (x0 > x1) begin
            xl = x1; yl = y1; xh = x0; yh = y0;
        end else begin
            xl = x0; yl = y0; xh = x1; yh = y1;
        end
        span     = (qx >= xl) && (qx < xh);
        dyl_next = DW'(qy) - DW'(yl);
        dxe_next = DW'(xh) - DW'(xl);
        dye_next = DW'(yh) - DW'(yl);
        dxp_next = DW'(qx) - DW'(xl);
    end

    assign pl_next = a_dyl_reg * a_dxe_reg;
    assign pr_next = a_dye_reg * a_dxp_reg;

    always_comb begin
        beyond = b_pl_reg > b_pr_reg;
        if (b_gtl_reg) begin
            toggle = b_gth_reg || beyond;
        end else begin
            toggle = b_gth_reg && beyond;
        end
        parity_next = parity_reg;
        if (ctrl.clear) begin
            parity_next = 1'b0;
        end else if (b_vld_reg && b_act_reg && toggle) begin
            parity_next = !parity_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            parity_reg <= 1'b0;
        end else begin
            a_vld_reg  <= ctrl.vld;
            b_vld_reg  <= a_vld_reg;
            parity_reg <= parity_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_act_reg <= ctrl.active && span;
        a_gtl_reg <= qy > yl;
        a_gth_reg <= qy > yh;
        a_dyl_reg <= dyl_next;
        a_dxe_reg <= dxe_next;
        a_dye_reg <= dye_next;
        a_dxp_reg <= dxp_next;
        b_act_reg <= a_act_reg;
        b_gtl_reg <= a_gtl_reg;
        b_gth_reg <= a_gth_reg;
        b_pl_reg  <= pl_next;
        b_pr_reg  <= pr_next;
    end

    assign stat.busy   = a_vld_reg || b_vld_reg;
    assign stat.parity = parity_reg;

endmodule

// ===== design/point_in_polygon_crossing_test_top.sv =====
// Top level of the point-in-polygon crossing test block.
//
// Usage:
//  s_ channel carries one item per handshake. s_tuser is the item kind:
//  start a new polygon with this vertex, append a vertex, or test a point.
//  s_tdata holds the vertex or query coordinates (signed Q16.8).
//  Vertex items give no result. Appends to a full store
//  are dropped and set a sticky overflow flag, cleared by the next start.
//  A query gives one item on m_: inside (odd crossing count) and overflow.
//  A query rotates the vertex ring once past one edge evaluator, one
//  vertex per cycle, and the evaluator adds three pipeline stages.
//  s_tready is low while a query runs; vertex items are taken in any idle
//  cycle, also while a result waits on m_.
//  If the receiver stalls, the finished query holds until the output
//  register is free; the result stays stable while m_tready is low.
//  Reset clears the vertex count, the overflow flag and all handshake
//  state; vertex storage is not cleared and needs no clearing pass.
module point_in_polygon_crossing_test_top #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF,
    parameter int SDW          = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [SDW-1:0] s_tdata,   // coord_x, coord_y, zero pad
    input  logic [1:0]     s_tuser,   // mode
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata    // inside_res, overflowed, zero pad
);
    import pip_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int IDXW = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);

    state_t state_reg, state_next;

    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic [IDXW-1:0] step_reg, step_next;
    logic            m_valid_reg, m_valid_next;
    logic [1:0]      m_bits_reg, m_bits_next;

    logic signed [W-1:0] in_x, in_y;
    logic signed [W-1:0] qx_reg, qy_reg;       // query point
    logic signed [W-1:0] last_x_reg, last_y_reg; // most recently stored vertex
    logic signed [W-1:0] prev_x_reg, prev_y_reg; // other end of current edge

    logic            accept, wr_en, start_q;
    logic [IDXW-1:0] wr_idx;

    logic signed [W-1:0] ring_x [MAX_VERTICES];
    logic signed [W-1:0] ring_y [MAX_VERTICES];

    edge_ctrl_t ectrl;
    edge_stat_t estat;

    assign in_x   = s_tdata[W-1:0];
    assign in_y   = s_tdata[2*W-1:W];
    assign accept = s_tvalid && s_tready;

    // Control: item decode, store bookkeeping, query sequencing, output slot
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_bits_next  = m_bits_reg;
        wr_en        = 1'b0;
        wr_idx       = '0;
        start_q      = 1'b0;
        s_tready     = 1'b0;
        ectrl        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    unique case (mode_t'(s_tuser))
                        MODE_START: begin
                            wr_en      = 1'b1;
                            count_next = CW'(1);
                            ovf_next   = 1'b0;
                        end
                        MODE_APPEND: begin
                            if (count_reg < CW'(MAX_VERTICES)) begin
                                wr_en      = 1'b1;
                                wr_idx     = count_reg[IDXW-1:0];
                                count_next = count_reg + CW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        MODE_QUERY: begin
                            start_q     = 1'b1;
                            ectrl.clear = 1'b1;
                            step_next   = '0;
                            state_next  = ST_RUN;
                        end
                        default: begin
                            // unused kind: ignored
                        end
                    endcase
                end
            end
            ST_RUN: begin
                // ring head holds vertex step_reg; only stored vertices count
                ectrl.vld    = 1'b1;
                ectrl.active = CW'(step_reg) < count_reg;
                step_next    = step_reg + IDXW'(1);
                if (step_reg == IDXW'(MAX_VERTICES - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the evaluator to empty and the output slot to free
                if (!estat.busy && (!m_valid_reg || m_tready)) begin
                    m_valid_next = 1'b1;
                    m_bits_next  = {ovf_reg, estat.parity};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        m_bits_reg <= m_bits_next;
        if (wr_en) begin
            last_x_reg <= in_x;
            last_y_reg <= in_y;
        end
        if (start_q) begin
            qx_reg     <= in_x;
            qy_reg     <= in_y;
            // first edge closes the polygon: last vertex to vertex 0
            prev_x_reg <= last_x_reg;
            prev_y_reg <= last_y_reg;
        end else if (state_reg == ST_RUN) begin
            prev_x_reg <= ring_x[0];
            prev_y_reg <= ring_y[0];
        end
    end

    // Vertex ring: one full turn per query brings every cell back in place
    for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_ring
        cell_ctrl_t cc;
        assign cc.shift = (state_reg == ST_RUN);
        assign cc.load  = wr_en && (wr_idx == IDXW'(i));

        pip_cell #(
            .W (W)
        ) u_cell (
            .aclk   (aclk),
            .ctrl   (cc),
            .load_x (in_x),
            .load_y (in_y),
            .nbr_x  (ring_x[(i + 1) % MAX_VERTICES]),
            .nbr_y  (ring_y[(i + 1) % MAX_VERTICES]),
            .vx     (ring_x[i]),
            .vy     (ring_y[i])
        );
    end

    pip_edge #(
        .W (W)
    ) u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ectrl),
        .qx      (qx_reg),
        .qy      (qy_reg),
        .x0      (ring_x[0]),
        .y0      (ring_y[0]),
        .x1      (prev_x_reg),
        .y1      (prev_y_reg),
        .stat    (estat)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_bits_reg};

endmodule

// ===== design/pip_checker.sv =====
// Port-level checks for the point-in-polygon crossing test block.
module pip_checker #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF,
    parameter int SDW          = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_tvalid,
    input logic           s_tready,
    input logic [SDW-1:0] s_tdata,
    input logic [1:0]     s_tuser,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [7:0]     m_tdata
);
    import pip_pkg::*;

    logic query_acc;
    assign query_acc = s_tvalid && s_tready && (s_tuser == MODE_QUERY);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // input closes once a query is taken
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        query_acc |=> !s_tready)
        else $error("input open right after a query");

    // a query walks the whole ring before input reopens
    a_query_len: assert property (@(posedge aclk) disable iff (!aresetn)
        query_acc |-> ##(MAX_VERTICES) !s_tready)
        else $error("query finished before ring turn completed");

    // a result only appears after a busy cycle
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a running query");

endmodule

bind point_in_polygon_crossing_test_top pip_checker #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH),
    .SDW          (SDW)
) u_pip_checker (.*);
